// File: hw/rtl/cda_pkg.sv
// cda_pkg: shared constants, types and microcode table for the calendar date-time adder
// holds field layout of the stream words, month length logic and the sequencer program
// no dependencies
`default_nettype none

package cda_pkg;

    // working width of every date-time register in the datapath
    localparam int WORK_W = 8;
    typedef logic [WORK_W-1:0] t_work;

    // input field widths
    localparam int S_YEAR_W  = 7;
    localparam int S_MONTH_W = 4;
    localparam int S_DAY_W   = 5;
    localparam int S_HOUR_W  = 5;
    localparam int S_MIN_W   = 6;
    localparam int S_SEC_W   = 6;
    localparam int ADD_W     = 7;

    // input packing, first field in the lowest bits
    localparam int IN_S_YEAR_LSB  = 0;
    localparam int IN_S_MONTH_LSB = IN_S_YEAR_LSB + S_YEAR_W;
    localparam int IN_S_DAY_LSB   = IN_S_MONTH_LSB + S_MONTH_W;
    localparam int IN_S_HOUR_LSB  = IN_S_DAY_LSB + S_DAY_W;
    localparam int IN_S_MIN_LSB   = IN_S_HOUR_LSB + S_HOUR_W;
    localparam int IN_S_SEC_LSB   = IN_S_MIN_LSB + S_MIN_W;
    localparam int IN_A_YEAR_LSB  = IN_S_SEC_LSB + S_SEC_W;
    localparam int IN_A_MONTH_LSB = IN_A_YEAR_LSB + ADD_W;
    localparam int IN_A_DAY_LSB   = IN_A_MONTH_LSB + ADD_W;
    localparam int IN_A_HOUR_LSB  = IN_A_DAY_LSB + ADD_W;
    localparam int IN_A_MIN_LSB   = IN_A_HOUR_LSB + ADD_W;
    localparam int IN_A_SEC_LSB   = IN_A_MIN_LSB + ADD_W;
    localparam int IN_BITS        = IN_A_SEC_LSB + ADD_W;
    localparam int IN_TDATA_W     = ((IN_BITS + 7) / 8) * 8;

    // output field widths
    localparam int O_YEAR_W  = 8;
    localparam int O_MONTH_W = 4;
    localparam int O_DAY_W   = 5;
    localparam int O_HOUR_W  = 5;
    localparam int O_MIN_W   = 6;
    localparam int O_SEC_W   = 6;

    localparam int OUT_YEAR_LSB  = 0;
    localparam int OUT_MONTH_LSB = OUT_YEAR_LSB + O_YEAR_W;
    localparam int OUT_DAY_LSB   = OUT_MONTH_LSB + O_MONTH_W;
    localparam int OUT_HOUR_LSB  = OUT_DAY_LSB + O_DAY_W;
    localparam int OUT_MIN_LSB   = OUT_HOUR_LSB + O_HOUR_W;
    localparam int OUT_SEC_LSB   = OUT_MIN_LSB + O_MIN_W;
    localparam int OUT_BITS      = OUT_SEC_LSB + O_SEC_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // calendar limits
    localparam t_work SEC_LIMIT   = 8'd59;
    localparam t_work SEC_MOD     = 8'd60;
    localparam t_work MIN_LIMIT   = 8'd59;
    localparam t_work MIN_MOD     = 8'd60;
    localparam t_work HOUR_LIMIT  = 8'd23;
    localparam t_work HOUR_MOD    = 8'd24;
    localparam t_work MONTH_LIMIT = 8'd12;
    localparam t_work MONTH_MOD   = 8'd12;
    localparam t_work LEN_31      = 8'd31;
    localparam t_work LEN_30      = 8'd30;
    localparam t_work LEN_29      = 8'd29;
    localparam t_work LEN_28      = 8'd28;
    localparam t_work LEN_NONE    = 8'd0;
    localparam t_work YEAR_2100   = 8'd100;
    localparam t_work YEAR_2200   = 8'd200;

    localparam t_work M_JAN = 8'd1;
    localparam t_work M_FEB = 8'd2;
    localparam t_work M_MAR = 8'd3;
    localparam t_work M_APR = 8'd4;
    localparam t_work M_MAY = 8'd5;
    localparam t_work M_JUN = 8'd6;
    localparam t_work M_JUL = 8'd7;
    localparam t_work M_AUG = 8'd8;
    localparam t_work M_SEP = 8'd9;
    localparam t_work M_OCT = 8'd10;
    localparam t_work M_NOV = 8'd11;
    localparam t_work M_DEC = 8'd12;

    // datapath unit that a microcode step works on
    typedef enum logic [2:0] {
        U_SEC  = 3'd0,
        U_MIN  = 3'd1,
        U_HOUR = 3'd2,
        U_DAY  = 3'd3,
        U_MON  = 3'd4
    } t_unit;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_SEC  = 3'd0;
    localparam t_pc PC_MIN  = 3'd1;
    localparam t_pc PC_HOUR = 3'd2;
    localparam t_pc PC_DAY  = 3'd3;
    localparam t_pc PC_MON  = 3'd4;

    // one control word: reduce while over the limit, else take the exit action
    typedef struct packed {
        t_unit unit;
        t_work limit;
        t_work modulus;
        t_pc   loop_pc;
        t_pc   exit_pc;
        logic  last;
    } t_ucode;

    function automatic t_ucode ucode_rom(input t_pc pc);
        t_ucode w;
        unique case (pc)
            PC_SEC:  w = t_ucode'{U_SEC, SEC_LIMIT, SEC_MOD, PC_SEC, PC_MIN, 1'b0};
            PC_MIN:  w = t_ucode'{U_MIN, MIN_LIMIT, MIN_MOD, PC_MIN, PC_HOUR, 1'b0};
            PC_HOUR: w = t_ucode'{U_HOUR, HOUR_LIMIT, HOUR_MOD, PC_HOUR, PC_DAY, 1'b0};
            // limit and modulus come from the month length
            PC_DAY:  w = t_ucode'{U_DAY, LEN_NONE, LEN_NONE, PC_DAY, PC_MON, 1'b0};
            PC_MON:  w = t_ucode'{U_MON, MONTH_LIMIT, MONTH_MOD, PC_MON, PC_SEC, 1'b1};
            default: w = t_ucode'{U_MON, MONTH_LIMIT, MONTH_MOD, PC_SEC, PC_SEC, 1'b1};
        endcase
        return w;
    endfunction

    // years 2100 and 2200 are not leap years, 2000 is
    function automatic logic is_leap(input t_work year);
        return (year[1:0] == 2'b00) && (year != YEAR_2100) && (year != YEAR_2200);
    endfunction

    // month outside january to december has no length
    function automatic t_work month_len(input t_work month, input t_work year);
        t_work len;
        unique case (month)
            M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: len = LEN_31;
            M_APR, M_JUN, M_SEP, M_NOV:                      len = LEN_30;
            M_FEB:   len = is_leap(year) ? LEN_29 : LEN_28;
            default: len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/calendar_datetime_adder_top.sv
// calendar_datetime_adder_top: adds a duration to a date-time, microcoded carry sequencer
// depends on cda_pkg for field layout, month lengths and the control word table
// sequence: on accept the request is loaded, then the seconds, minutes, hours, day and month
//   steps run in order, each repeated once per carry subtraction (the day step walks month by month)
// handshake: the next request is taken once the sequencer is free, while the previous
//   result may still wait in the output register
// reset: synchronous active low, clears the sequencer and the output valid
`default_nettype none

module calendar_datetime_adder_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // start_year, start_month, start_day, start_hour, start_minute, start_second,
    // add_years, add_months, add_days, add_hours, add_minutes, add_seconds, zero pad
    input  wire logic [cda_pkg::IN_TDATA_W-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // sum_year, sum_month, sum_day, sum_hour, sum_minute, sum_second, zero pad
    output logic [cda_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    logic                             r_busy, n_busy;
    logic                             r_out_valid, n_out_valid;
    cda_pkg::t_pc                     r_pc, n_pc;

    cda_pkg::t_work                   r_sec, n_sec;
    cda_pkg::t_work                   r_min, n_min;
    cda_pkg::t_work                   r_hour, n_hour;
    cda_pkg::t_work                   r_day, n_day;
    cda_pkg::t_work                   r_mon, n_mon;
    cda_pkg::t_work                   r_year, n_year;
    logic [cda_pkg::ADD_W-1:0]        r_a_year, n_a_year;
    logic [cda_pkg::ADD_W-1:0]        r_a_mon, n_a_mon;
    logic [cda_pkg::ADD_W-1:0]        r_a_day, n_a_day;
    logic [cda_pkg::ADD_W-1:0]        r_a_hour, n_a_hour;
    logic [cda_pkg::ADD_W-1:0]        r_a_min, n_a_min;
    logic [cda_pkg::OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    cda_pkg::t_ucode                  ctl;
    cda_pkg::t_work                   val, lim, modulus, diff, len, mon_inc;
    logic                             over, s_accept, out_free, stall;

    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign s_accept = i_s_tvalid && !r_busy;
    assign out_free = !r_out_valid || i_m_tready;

    // shared compare and subtract
    always_comb begin
        ctl = cda_pkg::ucode_rom(r_pc);
        len = cda_pkg::month_len(r_mon, r_year);
        unique case (ctl.unit)
            cda_pkg::U_SEC:  val = r_sec;
            cda_pkg::U_MIN:  val = r_min;
            cda_pkg::U_HOUR: val = r_hour;
            cda_pkg::U_DAY:  val = r_day;
            cda_pkg::U_MON:  val = r_mon;
            default:         val = r_mon;
        endcase
        lim     = (ctl.unit == cda_pkg::U_DAY) ? len : ctl.limit;
        modulus = (ctl.unit == cda_pkg::U_DAY) ? len : ctl.modulus;
        over    = val > lim;
        diff    = val - modulus;
        mon_inc = r_mon + cda_pkg::t_work'(1);
        stall   = ctl.last && !over && !out_free;
    end

    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hour      = r_hour;
        n_day       = r_day;
        n_mon       = r_mon;
        n_year      = r_year;
        n_a_year    = r_a_year;
        n_a_mon     = r_a_mon;
        n_a_day     = r_a_day;
        n_a_hour    = r_a_hour;
        n_a_min     = r_a_min;

        if (s_accept) begin
            n_busy   = 1'b1;
            n_pc     = cda_pkg::PC_SEC;
            n_sec    = cda_pkg::t_work'(i_s_tdata[cda_pkg::IN_S_SEC_LSB +: cda_pkg::S_SEC_W])
                     + cda_pkg::t_work'(i_s_tdata[cda_pkg::IN_A_SEC_LSB +: cda_pkg::ADD_W]);
            n_min    = cda_pkg::t_work'(i_s_tdata[cda_pkg::IN_S_MIN_LSB +: cda_pkg::S_MIN_W]);
            n_hour   = cda_pkg::t_work'(i_s_tdata[cda_pkg::IN_S_HOUR_LSB +: cda_pkg::S_HOUR_W]);
            n_day    = cda_pkg::t_work'(i_s_tdata[cda_pkg::IN_S_DAY_LSB +: cda_pkg::S_DAY_W]);
            n_mon    = cda_pkg::t_work'(i_s_tdata[cda_pkg::IN_S_MONTH_LSB +: cda_pkg::S_MONTH_W]);
            n_year   = cda_pkg::t_work'(i_s_tdata[cda_pkg::IN_S_YEAR_LSB +: cda_pkg::S_YEAR_W]);
            n_a_year = i_s_tdata[cda_pkg::IN_A_YEAR_LSB +: cda_pkg::ADD_W];
            n_a_mon  = i_s_tdata[cda_pkg::IN_A_MONTH_LSB +: cda_pkg::ADD_W];
            n_a_day  = i_s_tdata[cda_pkg::IN_A_DAY_LSB +: cda_pkg::ADD_W];
            n_a_hour = i_s_tdata[cda_pkg::IN_A_HOUR_LSB +: cda_pkg::ADD_W];
            n_a_min  = i_s_tdata[cda_pkg::IN_A_MIN_LSB +: cda_pkg::ADD_W];
        end else if (r_busy && !stall) begin
            n_pc = over ? ctl.loop_pc : ctl.exit_pc;
            unique case (ctl.unit)
                cda_pkg::U_SEC: begin
                    if (over) begin
                        n_sec = diff;
                        n_min = r_min + cda_pkg::t_work'(1);
                    end else begin
                        n_min = r_min + cda_pkg::t_work'(r_a_min);
                    end
                end
                cda_pkg::U_MIN: begin
                    if (over) begin
                        n_min  = diff;
                        n_hour = r_hour + cda_pkg::t_work'(1);
                    end else begin
                        n_hour = r_hour + cda_pkg::t_work'(r_a_hour);
                    end
                end
                cda_pkg::U_HOUR: begin
                    if (over) begin
                        n_hour = diff;
                        n_day  = r_day + cda_pkg::t_work'(1);
                    end else begin
                        n_day = r_day + cda_pkg::t_work'(r_a_day);
                    end
                end
                cda_pkg::U_DAY: begin
                    if (over) begin
                        n_day = diff;
                        if (mon_inc > cda_pkg::MONTH_LIMIT) begin
                            n_mon  = mon_inc - cda_pkg::MONTH_MOD;
                            n_year = r_year + cda_pkg::t_work'(1);
                        end else begin
                            n_mon = mon_inc;
                        end
                    end else begin
                        n_mon = r_mon + cda_pkg::t_work'(r_a_mon);
                    end
                end
                default: begin
                    if (over) begin
                        n_mon  = diff;
                        n_year = r_year + cda_pkg::t_work'(1);
                    end else begin
                        n_year = r_year + cda_pkg::t_work'(r_a_year);
                    end
                end
            endcase

            if (ctl.last && !over) begin
                n_busy      = 1'b0;
                n_out_valid = 1'b1;
                n_out_data  = '0;
                n_out_data[cda_pkg::OUT_YEAR_LSB +: cda_pkg::O_YEAR_W]   = n_year;
                n_out_data[cda_pkg::OUT_MONTH_LSB +: cda_pkg::O_MONTH_W] =
                    r_mon[cda_pkg::O_MONTH_W-1:0];
                n_out_data[cda_pkg::OUT_DAY_LSB +: cda_pkg::O_DAY_W]     =
                    r_day[cda_pkg::O_DAY_W-1:0];
                n_out_data[cda_pkg::OUT_HOUR_LSB +: cda_pkg::O_HOUR_W]   =
                    r_hour[cda_pkg::O_HOUR_W-1:0];
                n_out_data[cda_pkg::OUT_MIN_LSB +: cda_pkg::O_MIN_W]     =
                    r_min[cda_pkg::O_MIN_W-1:0];
                n_out_data[cda_pkg::OUT_SEC_LSB +: cda_pkg::O_SEC_W]     =
                    r_sec[cda_pkg::O_SEC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= cda_pkg::PC_SEC;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_pc        <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec      <= n_sec;
        r_min      <= n_min;
        r_hour     <= n_hour;
        r_day      <= n_day;
        r_mon      <= n_mon;
        r_year     <= n_year;
        r_a_year   <= n_a_year;
        r_a_mon    <= n_a_mon;
        r_a_day    <= n_a_day;
        r_a_hour   <= n_a_hour;
        r_a_min    <= n_a_min;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

// File: hw/rtl/cda_checker.sv
// cda_checker: port-level assertions for the calendar date-time adder, bound to the top level
// depends on cda_pkg for the output field layout and calendar limits
`default_nettype none

module cda_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [cda_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // a request in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while a previous one is in flight");

    // clock fields always come out normalised
    a_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (o_m_tdata[cda_pkg::OUT_SEC_LSB +: cda_pkg::O_SEC_W]
                <= cda_pkg::SEC_LIMIT[cda_pkg::O_SEC_W-1:0]) &&
            (o_m_tdata[cda_pkg::OUT_MIN_LSB +: cda_pkg::O_MIN_W]
                <= cda_pkg::MIN_LIMIT[cda_pkg::O_MIN_W-1:0]) &&
            (o_m_tdata[cda_pkg::OUT_HOUR_LSB +: cda_pkg::O_HOUR_W]
                <= cda_pkg::HOUR_LIMIT[cda_pkg::O_HOUR_W-1:0]))
        else $error("result time field out of range");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("outputs not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result dropped or changed");

endmodule

bind calendar_datetime_adder_top cda_checker u_cda_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
